// File: design/jsu_pkg.sv
package jsu_pkg;

   localparam int CAP_W                = 13;
   localparam int BYTE_W               = 8;
   localparam int CODE_W               = 3;
   localparam int KIND_W               = 2;
   localparam int MAX_RESULTS          = 4;
   localparam int GCNT_W               = 3;
   localparam int DEFAULT_MAX_CAPACITY = 4096;

   localparam logic [CAP_W-1:0] CAP_RESET = 13'd256;

   typedef enum logic [KIND_W-1:0] {
      KIND_DATA = 2'd0,
      KIND_DONE = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   localparam logic [CODE_W-1:0] ERR_START     = 3'd0;
   localparam logic [CODE_W-1:0] ERR_CTRL      = 3'd1;
   localparam logic [CODE_W-1:0] ERR_ESCAPE    = 3'd2;
   localparam logic [CODE_W-1:0] ERR_HEX       = 3'd3;
   localparam logic [CODE_W-1:0] ERR_SURROGATE = 3'd4;
   localparam logic [CODE_W-1:0] ERR_CODEPOINT = 3'd5;
   localparam logic [CODE_W-1:0] ERR_OVERFLOW  = 3'd6;
   localparam logic [CODE_W-1:0] ERR_TRUNC     = 3'd7;

   localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
   localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5c;
   localparam logic [BYTE_W-1:0] CH_SLASH     = 8'h2f;
   localparam logic [BYTE_W-1:0] CH_N         = 8'h6e;
   localparam logic [BYTE_W-1:0] CH_R         = 8'h72;
   localparam logic [BYTE_W-1:0] CH_T         = 8'h74;
   localparam logic [BYTE_W-1:0] CH_U         = 8'h75;
   localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [BYTE_W-1:0] CH_LF        = 8'h0a;
   localparam logic [BYTE_W-1:0] CH_CR        = 8'h0d;
   localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;

   typedef enum logic [3:0] {
      M_IDLE,
      M_BODY,
      M_ESC,
      M_HEX1_0,
      M_HEX1_1,
      M_HEX1_2,
      M_HEX1_3,
      M_WANT_BS,
      M_WANT_U,
      M_HEX2_0,
      M_HEX2_1,
      M_HEX2_2,
      M_HEX2_3
   } mode_type;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              start_req;
      logic              end_of_buffer;
   } req_item_type;

   // All results caused by one input byte; data[0] goes out first.
   typedef struct packed {
      logic [GCNT_W-1:0]                   cnt;
      kind_type                            kind;
      logic [CODE_W-1:0]                   code;
      logic [MAX_RESULTS-1:0][BYTE_W-1:0]  data;
   } result_group_type;

endpackage

// File: design/jsu_decode.sv
module jsu_decode #(
   parameter int MAX_CAPACITY = jsu_pkg::DEFAULT_MAX_CAPACITY
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  jsu_pkg::req_item_type      item,
   input  logic [jsu_pkg::CAP_W-1:0]  capacity,
   output jsu_pkg::result_group_type  grp
);
   import jsu_pkg::*;

   localparam int MAXC_W = $clog2(MAX_CAPACITY + 1);
   localparam int CMP_W  = (MAXC_W > CAP_W) ? MAXC_W : CAP_W;

   mode_type           mode_ff, mode_in, mode_step;
   logic [15:0]        hex_ff, hex_in, hex_step;
   logic [9:0]         hs_ff, hs_in, hs_step;
   logic [CAP_W-1:0]   count_ff, count_in;

   logic [CAP_W-1:0]   eff_cap;
   logic [7:0]         byte_v;
   logic               hex_ok;
   logic [3:0]         hex_val;
   logic [15:0]        acc;
   logic               acc_hi, acc_lo;
   logic [20:0]        cp;
   logic               cp_reject;
   logic [GCNT_W-1:0]  enc_n;
   logic [MAX_RESULTS-1:0][BYTE_W-1:0] enc_bytes;

   logic               ev_err, ev_done, emit_try;
   logic [CODE_W-1:0]  ev_code;
   logic [GCNT_W-1:0]  emit_n;
   logic [MAX_RESULTS-1:0][BYTE_W-1:0] emit_bytes;
   logic [CAP_W:0]     sum;
   logic               fits, overflow, err_any, active, trunc, terminate;
   logic [CODE_W-1:0]  err_code;

   // Register values above the build limit act as the limit.
   assign eff_cap = (CMP_W'(capacity) > CMP_W'(MAX_CAPACITY)) ?
                    CAP_W'(MAX_CAPACITY) : capacity;

   assign byte_v = item.in_byte;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (byte_v >= 8'h30 && byte_v <= 8'h39) begin
         hex_val = byte_v[3:0];
      end else if ((byte_v >= 8'h61 && byte_v <= 8'h66) ||
                   (byte_v >= 8'h41 && byte_v <= 8'h46)) begin
         hex_val = byte_v[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign acc    = {hex_ff[11:0], hex_val};
   assign acc_hi = (acc[15:10] == 6'b110110);
   assign acc_lo = (acc[15:10] == 6'b110111);

   assign cp = (mode_ff == M_HEX2_3) ? (21'h10000 + {1'b0, hs_ff, acc[9:0]})
                                     : {5'd0, acc};
   assign cp_reject = (cp < 21'(CH_SPACE)) && (cp != 21'(CH_LF));

   // UTF-8 encoder
   always_comb begin
      enc_bytes = '0;
      if (cp <= 21'h7f) begin
         enc_n        = 3'd1;
         enc_bytes[0] = cp[7:0];
      end else if (cp <= 21'h7ff) begin
         enc_n        = 3'd2;
         enc_bytes[0] = {3'b110, cp[10:6]};
         enc_bytes[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'hffff) begin
         enc_n        = 3'd3;
         enc_bytes[0] = {4'b1110, cp[15:12]};
         enc_bytes[1] = {2'b10, cp[11:6]};
         enc_bytes[2] = {2'b10, cp[5:0]};
      end else begin
         enc_n        = 3'd4;
         enc_bytes[0] = {5'b11110, cp[20:18]};
         enc_bytes[1] = {2'b10, cp[17:12]};
         enc_bytes[2] = {2'b10, cp[11:6]};
         enc_bytes[3] = {2'b10, cp[5:0]};
      end
   end

   // What the current byte means in the current mode
   always_comb begin
      ev_err     = 1'b0;
      ev_code    = ERR_START;
      ev_done    = 1'b0;
      emit_try   = 1'b0;
      emit_n     = 3'd1;
      emit_bytes = '0;
      mode_step  = mode_ff;
      hex_step   = hex_ff;
      hs_step    = hs_ff;
      if (item.start_req) begin
         mode_step = M_BODY;
         if (eff_cap == '0 || byte_v != CH_QUOTE) begin
            ev_err = 1'b1;
         end
      end else begin
         case (mode_ff)
            M_BODY: begin
               if (byte_v == CH_QUOTE) begin
                  ev_done = 1'b1;
               end else if (byte_v < CH_SPACE) begin
                  ev_err  = 1'b1;
                  ev_code = ERR_CTRL;
               end else if (byte_v == CH_BACKSLASH) begin
                  mode_step = M_ESC;
               end else begin
                  emit_try      = 1'b1;
                  emit_bytes[0] = byte_v;
               end
            end
            M_ESC: begin
               mode_step = M_BODY;
               if (byte_v == CH_QUOTE || byte_v == CH_BACKSLASH || byte_v == CH_SLASH) begin
                  emit_try      = 1'b1;
                  emit_bytes[0] = byte_v;
               end else if (byte_v == CH_N) begin
                  emit_try      = 1'b1;
                  emit_bytes[0] = CH_LF;
               end else if (byte_v == CH_R) begin
                  emit_try      = 1'b1;
                  emit_bytes[0] = CH_CR;
               end else if (byte_v == CH_T) begin
                  emit_try      = 1'b1;
                  emit_bytes[0] = CH_TAB;
               end else if (byte_v == CH_U) begin
                  hex_step  = '0;
                  mode_step = M_HEX1_0;
               end else begin
                  ev_err  = 1'b1;
                  ev_code = ERR_ESCAPE;
               end
            end
            M_HEX1_0, M_HEX1_1, M_HEX1_2, M_HEX2_0, M_HEX2_1, M_HEX2_2: begin
               if (!hex_ok) begin
                  ev_err  = 1'b1;
                  ev_code = ERR_HEX;
               end else begin
                  hex_step  = acc;
                  mode_step = mode_type'(mode_ff + 4'd1);
               end
            end
            M_HEX1_3: begin
               if (!hex_ok) begin
                  ev_err  = 1'b1;
                  ev_code = ERR_HEX;
               end else if (acc_hi) begin
                  hex_step  = acc;
                  hs_step   = acc[9:0];
                  mode_step = M_WANT_BS;
               end else if (acc_lo) begin
                  ev_err  = 1'b1;
                  ev_code = ERR_SURROGATE;
               end else if (cp_reject) begin
                  ev_err  = 1'b1;
                  ev_code = ERR_CODEPOINT;
               end else begin
                  hex_step   = acc;
                  mode_step  = M_BODY;
                  emit_try   = 1'b1;
                  emit_n     = enc_n;
                  emit_bytes = enc_bytes;
               end
            end
            M_HEX2_3: begin
               if (!hex_ok) begin
                  ev_err  = 1'b1;
                  ev_code = ERR_HEX;
               end else if (!acc_lo) begin
                  ev_err  = 1'b1;
                  ev_code = ERR_SURROGATE;
               end else begin
                  hex_step   = acc;
                  mode_step  = M_BODY;
                  emit_try   = 1'b1;
                  emit_n     = enc_n;
                  emit_bytes = enc_bytes;
               end
            end
            M_WANT_BS: begin
               if (byte_v == CH_BACKSLASH) begin
                  mode_step = M_WANT_U;
               end else begin
                  ev_err  = 1'b1;
                  ev_code = ERR_SURROGATE;
               end
            end
            M_WANT_U: begin
               if (byte_v == CH_U) begin
                  hex_step  = '0;
                  mode_step = M_HEX2_0;
               end else begin
                  ev_err  = 1'b1;
                  ev_code = ERR_SURROGATE;
               end
            end
            default: begin
               mode_step = M_IDLE;
            end
         endcase
      end
   end

   // Whole encoding must fit below the terminator slot, else nothing goes out.
   assign sum      = {1'b0, count_ff} + (CAP_W + 1)'(emit_n);
   assign fits     = sum < {1'b0, eff_cap};
   assign overflow = emit_try && !fits;
   assign err_any  = ev_err || overflow;
   assign err_code = ev_err ? ev_code : ERR_OVERFLOW;
   assign active   = item.start_req || (mode_ff != M_IDLE);
   assign trunc    = active && item.end_of_buffer && !err_any && !ev_done;
   assign terminate = err_any || ev_done || trunc;

   // Next state
   always_comb begin
      mode_in  = mode_ff;
      hex_in   = hex_ff;
      hs_in    = hs_ff;
      count_in = count_ff;
      if (fire) begin
         if (item.start_req) begin
            mode_in  = terminate ? M_IDLE : M_BODY;
            hex_in   = '0;
            hs_in    = '0;
            count_in = '0;
         end else begin
            mode_in = terminate ? M_IDLE : mode_step;
            hex_in  = hex_step;
            hs_in   = hs_step;
            if (emit_try && !terminate) begin
               count_in = count_ff + CAP_W'(emit_n);
            end
         end
      end
   end

   // Results of the current byte
   always_comb begin
      grp      = '0;
      grp.kind = KIND_DATA;
      if (err_any) begin
         grp.cnt  = 3'd1;
         grp.kind = KIND_ERR;
         grp.code = err_code;
      end else if (ev_done) begin
         grp.cnt  = 3'd1;
         grp.kind = KIND_DONE;
      end else if (trunc) begin
         grp.cnt  = 3'd1;
         grp.kind = KIND_ERR;
         grp.code = ERR_TRUNC;
      end else if (emit_try) begin
         grp.cnt  = emit_n;
         grp.data = emit_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         hex_ff   <= '0;
         hs_ff    <= '0;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         hex_ff   <= hex_in;
         hs_ff    <= hs_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      fire && mode_ff == M_IDLE && !item.start_req |-> grp.cnt == '0)
      else $error("byte outside a string produced a result");

   a_end_to_idle: assert property (@(posedge clock) disable iff (reset)
      fire && grp.cnt != '0 && grp.kind != KIND_DATA |=> mode_ff == M_IDLE)
      else $error("string not closed after completion or error");

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(mode_ff) && $stable(count_ff))
      else $error("parse state moved without a byte");
`endif

endmodule

// File: design/jsu_rsp_buf.sv
module jsu_rsp_buf (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  jsu_pkg::result_group_type    grp,
   output logic                         free,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [jsu_pkg::KIND_W-1:0]   rsp_kind,
   output logic [jsu_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic [jsu_pkg::CODE_W-1:0]   rsp_error_code,
   output logic                         rsp_last_of_run
);
   import jsu_pkg::*;

   logic [GCNT_W-1:0]                  cnt_ff, cnt_in;
   kind_type                           kind_ff, kind_in;
   logic [CODE_W-1:0]                  code_ff, code_in;
   logic [MAX_RESULTS-1:0][BYTE_W-1:0] data_ff, data_in;
   logic                               take;

   assign rsp_valid       = (cnt_ff != '0);
   assign take            = rsp_valid && !rsp_stall;
   // Room for a new group once the last pending result transfers.
   assign free            = (cnt_ff == '0) || (cnt_ff == 3'd1 && take);
   assign rsp_kind        = kind_ff;
   assign rsp_out_byte    = data_ff[0];
   assign rsp_error_code  = code_ff;
   assign rsp_last_of_run = (cnt_ff == 3'd1);

   always_comb begin
      cnt_in  = cnt_ff;
      kind_in = kind_ff;
      code_in = code_ff;
      data_in = data_ff;
      if (load) begin
         cnt_in  = grp.cnt;
         kind_in = grp.kind;
         code_in = grp.code;
         data_in = grp.data;
      end else if (take) begin
         cnt_in  = cnt_ff - 3'd1;
         data_in = {8'h00, data_ff[MAX_RESULTS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      code_ff <= code_in;
      data_ff <= data_in;
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(MAX_RESULTS))
      else $error("result count out of range");

   a_status_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind_ff != KIND_DATA |-> cnt_ff == 3'd1)
      else $error("completion or error not the only result");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      take && cnt_ff > 3'd1 |=> rsp_valid && kind_ff == KIND_DATA)
      else $error("multi-byte run broken");
`endif

endmodule

// File: design/json_string_unescape_utf8.sv
// Streaming decoder for one quoted JSON string: one buffer byte per transfer
// in, decoded UTF-8 bytes, a completion mark or an error code out, one result
// per transfer, with last_of_run set on the final result of each input byte.
// A byte goes through an input register, is decoded combinationally, and its
// results are loaded into a result register, from which they are offered. One
// input byte is taken per cycle as long as it yields at most one result and
// the output does not stall; a \u escape that completes a code point yields up
// to four bytes, which leave one per cycle from the result register while the
// output does not stall, so that byte holds the input side until its last
// result transfers. The capacity register may be written only while no string
// byte is in flight.
module json_string_unescape_utf8 #(
   parameter int MAX_CAPACITY = jsu_pkg::DEFAULT_MAX_CAPACITY
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [jsu_pkg::BYTE_W-1:0]  req_in_byte,
   input  logic                        req_start_req,
   input  logic                        req_end_of_buffer,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [jsu_pkg::KIND_W-1:0]  rsp_kind,
   output logic [jsu_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic [jsu_pkg::CODE_W-1:0]  rsp_error_code,
   output logic                        rsp_last_of_run,
   input  logic                        csr_write,
   input  logic [jsu_pkg::CAP_W-1:0]   csr_wdata
);
   import jsu_pkg::*;

   logic              in_vld_ff, in_vld_in;
   req_item_type      in_ff, in_in;
   logic [CAP_W-1:0]  capacity_ff, capacity_in;
   result_group_type  grp;
   logic              buf_free, advance, load, accept;

   assign advance   = in_vld_ff && (buf_free || grp.cnt == '0);
   assign load      = advance && grp.cnt != '0;
   assign req_stall = in_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_vld_in   = in_vld_ff;
      in_in       = in_ff;
      capacity_in = capacity_ff;
      if (accept) begin
         in_vld_in           = 1'b1;
         in_in.in_byte       = req_in_byte;
         in_in.start_req     = req_start_req;
         in_in.end_of_buffer = req_end_of_buffer;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      if (csr_write) begin
         capacity_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         capacity_ff <= CAP_RESET;
      end else begin
         in_vld_ff   <= in_vld_in;
         capacity_ff <= capacity_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

   jsu_decode #(
      .MAX_CAPACITY (MAX_CAPACITY)
   ) u_decode (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .item     (in_ff),
      .capacity (capacity_ff),
      .grp      (grp)
   );

   jsu_rsp_buf u_rsp_buf (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .grp             (grp),
      .free            (buf_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// File: dv/tb_json_string_unescape_utf8.sv
`timescale 1ns / 100ps

module tb_json_string_unescape_utf8;
   import jsu_pkg::*;

   localparam int CAP_LIMIT      = DEFAULT_MAX_CAPACITY;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 6;

   localparam logic [CODE_W-1:0] NO_CODE = '0;

   typedef enum logic [1:0] {
      CHK_PRED,
      CHK_NONE,
      CHK_ONE
   } chk_type;

   typedef struct packed {
      logic [BYTE_W-1:0] b;
      logic              st;
      logic              eob;
      chk_type           chk;
      kind_type          kind;
      logic [BYTE_W-1:0] data;
      logic [CODE_W-1:0] code;
   } stim_row_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] data;
      logic [CODE_W-1:0] code;
      logic              last;
   } decoded_type;

   // directed rows: typed expectations where obvious, predictor otherwise
   localparam stim_row_type DIRECTED_ROWS [28] = '{
      '{8'h41,        1'b0, 1'b0, CHK_NONE, KIND_DATA, 8'h00,  NO_CODE},
      '{CH_QUOTE,     1'b1, 1'b0, CHK_NONE, KIND_DATA, 8'h00,  NO_CODE},
      '{8'hff,        1'b0, 1'b0, CHK_ONE,  KIND_DATA, 8'hff,  NO_CODE},
      '{CH_BACKSLASH, 1'b0, 1'b0, CHK_NONE, KIND_DATA, 8'h00,  NO_CODE},
      '{CH_N,         1'b0, 1'b0, CHK_ONE,  KIND_DATA, CH_LF,  NO_CODE},
      '{CH_BACKSLASH, 1'b0, 1'b0, CHK_NONE, KIND_DATA, 8'h00,  NO_CODE},
      '{CH_U,         1'b0, 1'b0, CHK_NONE, KIND_DATA, 8'h00,  NO_CODE},
      '{8'h30,        1'b0, 1'b0, CHK_PRED, KIND_DATA, 8'h00,  NO_CODE},
      '{8'h30,        1'b0, 1'b0, CHK_PRED, KIND_DATA, 8'h00,  NO_CODE},
      '{8'h31,        1'b0, 1'b0, CHK_PRED, KIND_DATA, 8'h00,  NO_CODE},
      '{8'h66,        1'b0, 1'b0, CHK_ONE,  KIND_ERR,  8'h00,  ERR_CODEPOINT},
      '{CH_QUOTE,     1'b1, 1'b0, CHK_NONE, KIND_DATA, 8'h00,  NO_CODE},
      '{CH_BACKSLASH, 1'b0, 1'b0, CHK_NONE, KIND_DATA, 8'h00,  NO_CODE},
      '{CH_U,         1'b0, 1'b0, CHK_NONE, KIND_DATA, 8'h00,  NO_CODE},
      '{8'h44,        1'b0, 1'b0, CHK_PRED, KIND_DATA, 8'h00,  NO_CODE},
      '{8'h43,        1'b0, 1'b0, CHK_PRED, KIND_DATA, 8'h00,  NO_CODE},
      '{8'h30,        1'b0, 1'b0, CHK_PRED, KIND_DATA, 8'h00,  NO_CODE},
      '{8'h67,        1'b0, 1'b0, CHK_ONE,  KIND_ERR,  8'h00,  ERR_HEX},
      '{8'h00,        1'b1, 1'b0, CHK_ONE,  KIND_ERR,  8'h00,  ERR_START},
      '{CH_QUOTE,     1'b1, 1'b1, CHK_ONE,  KIND_ERR,  8'h00,  ERR_TRUNC},
      '{CH_QUOTE,     1'b1, 1'b0, CHK_NONE, KIND_DATA, 8'h00,  NO_CODE},
      '{8'h1f,        1'b0, 1'b0, CHK_ONE,  KIND_ERR,  8'h00,  ERR_CTRL},
      '{CH_QUOTE,     1'b1, 1'b0, CHK_NONE, KIND_DATA, 8'h00,  NO_CODE},
      '{CH_SPACE,     1'b0, 1'b1, CHK_ONE,  KIND_ERR,  8'h00,  ERR_TRUNC},
      '{CH_QUOTE,     1'b1, 1'b0, CHK_NONE, KIND_DATA, 8'h00,  NO_CODE},
      '{CH_QUOTE,     1'b1, 1'b0, CHK_NONE, KIND_DATA, 8'h00,  NO_CODE},
      '{CH_BACKSLASH, 1'b0, 1'b0, CHK_NONE, KIND_DATA, 8'h00,  NO_CODE},
      '{8'h71,        1'b0, 1'b0, CHK_ONE,  KIND_ERR,  8'h00,  ERR_ESCAPE}
   };

   logic                clock;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_in_byte       = '0;
   logic                req_start_req     = 1'b0;
   logic                req_end_of_buffer = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall         = 1'b0;
   logic [KIND_W-1:0]   rsp_kind;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic [CODE_W-1:0]   rsp_error_code;
   logic                rsp_last_of_run;
   logic                csr_write         = 1'b0;
   logic [CAP_W-1:0]    csr_wdata         = '0;

   bit          jitter_on    = 1'b1;
   int          mismatches   = 0;
   int          sent_items   = 0;
   int          phase_end    = 0;
   int          stuck_cycles = 0;
   decoded_type due_results [$];
   decoded_type decode_out [$];

   // decoder shadow state
   mode_type         dec_mode = M_IDLE;
   logic [15:0]      hex_acc  = '0;
   logic [9:0]       hi_bits  = '0;
   int               emitted  = 0;
   logic [CAP_W-1:0] cap_reg  = CAP_RESET;

   json_string_unescape_utf8 #(.MAX_CAPACITY(CAP_LIMIT)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_start_req     (req_start_req),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_error_code    (rsp_error_code),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_write         (csr_write),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic decoded_type result_of(input kind_type k, input logic [BYTE_W-1:0] d,
                                             input logic [CODE_W-1:0] c, input logic l);
      return '{k, d, c, l};
   endfunction

   // Advance the shadow decoder by one buffer byte; results land in decode_out.
   task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic st, input logic eob);
      logic [BYTE_W-1:0] enc [4];
      int                n_enc;
      int                lim;
      int                dig;
      logic              fault;
      logic              done;
      logic              have_cp;
      logic [CODE_W-1:0] fault_code;
      logic [20:0]       cp;
      decode_out.delete();
      n_enc = 0;
      dig = -1;
      fault = 1'b0;
      done = 1'b0;
      have_cp = 1'b0;
      fault_code = NO_CODE;
      cp = '0;
      lim = (cap_reg > CAP_LIMIT) ? CAP_LIMIT : int'(cap_reg);
      if (st) begin
         dec_mode = M_IDLE;
         hex_acc = '0;
         hi_bits = '0;
         emitted = 0;
         if (lim == 0 || b != CH_QUOTE) begin
            decode_out.push_back(result_of(KIND_ERR, 8'h00, ERR_START, 1'b1));
         end else if (eob) begin
            decode_out.push_back(result_of(KIND_ERR, 8'h00, ERR_TRUNC, 1'b1));
         end else begin
            dec_mode = M_BODY;
         end
         return;
      end
      if (dec_mode == M_IDLE) return;
      case (dec_mode)
         M_BODY: begin
            if (b == CH_QUOTE) done = 1'b1;
            else if (b < CH_SPACE) begin
               fault = 1'b1;
               fault_code = ERR_CTRL;
            end else if (b == CH_BACKSLASH) dec_mode = M_ESC;
            else begin
               enc[0] = b;
               n_enc = 1;
            end
         end
         M_ESC: begin
            dec_mode = M_BODY;
            n_enc = 1;
            case (b)
               CH_QUOTE, CH_BACKSLASH, CH_SLASH: enc[0] = b;
               CH_N: enc[0] = CH_LF;
               CH_R: enc[0] = CH_CR;
               CH_T: enc[0] = CH_TAB;
               CH_U: begin
                  n_enc = 0;
                  hex_acc = '0;
                  dec_mode = M_HEX1_0;
               end
               default: begin
                  n_enc = 0;
                  fault = 1'b1;
                  fault_code = ERR_ESCAPE;
               end
            endcase
         end
         M_WANT_BS: begin
            if (b == CH_BACKSLASH) dec_mode = M_WANT_U;
            else begin
               fault = 1'b1;
               fault_code = ERR_SURROGATE;
            end
         end
         M_WANT_U: begin
            if (b == CH_U) begin
               hex_acc = '0;
               dec_mode = M_HEX2_0;
            end else begin
               fault = 1'b1;
               fault_code = ERR_SURROGATE;
            end
         end
         default: begin
            if (b >= 8'h30 && b <= 8'h39) dig = b - 8'h30;
            else if (b >= 8'h61 && b <= 8'h66) dig = b - 8'h57;
            else if (b >= 8'h41 && b <= 8'h46) dig = b - 8'h37;
            if (dig < 0) begin
               fault = 1'b1;
               fault_code = ERR_HEX;
            end else begin
               hex_acc = {hex_acc[11:0], dig[3:0]};
               if (dec_mode == M_HEX1_3) begin
                  if (hex_acc >= 16'hd800 && hex_acc <= 16'hdbff) begin
                     hi_bits = hex_acc[9:0];
                     dec_mode = M_WANT_BS;
                  end else if (hex_acc >= 16'hdc00 && hex_acc <= 16'hdfff) begin
                     fault = 1'b1;
                     fault_code = ERR_SURROGATE;
                  end else begin
                     dec_mode = M_BODY;
                     cp = {5'd0, hex_acc};
                     have_cp = 1'b1;
                  end
               end else if (dec_mode == M_HEX2_3) begin
                  if (hex_acc < 16'hdc00 || hex_acc > 16'hdfff) begin
                     fault = 1'b1;
                     fault_code = ERR_SURROGATE;
                  end else begin
                     dec_mode = M_BODY;
                     cp = 21'h10000 + {1'b0, hi_bits, hex_acc[9:0]};
                     have_cp = 1'b1;
                  end
               end else begin
                  dec_mode = mode_type'(dec_mode + 4'd1);
               end
            end
         end
      endcase
      if (have_cp) begin
         if (cp < 21'h20 && cp != 21'h0a) begin
            fault = 1'b1;
            fault_code = ERR_CODEPOINT;
         end else if (cp <= 21'h7f) begin
            enc[0] = cp[7:0];
            n_enc = 1;
         end else if (cp <= 21'h7ff) begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
            n_enc = 2;
         end else if (cp <= 21'hffff) begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
            n_enc = 3;
         end else begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
            n_enc = 4;
         end
      end
      // whole encoding must fit below capacity, else nothing goes out
      if (!fault && n_enc != 0) begin
         if (emitted + n_enc >= lim) begin
            fault = 1'b1;
            fault_code = ERR_OVERFLOW;
         end else begin
            emitted += n_enc;
         end
      end
      if (fault || done || eob) begin
         dec_mode = M_IDLE;
         if (fault) decode_out.push_back(result_of(KIND_ERR, 8'h00, fault_code, 1'b1));
         else if (done) decode_out.push_back(result_of(KIND_DONE, 8'h00, NO_CODE, 1'b1));
         else decode_out.push_back(result_of(KIND_ERR, 8'h00, ERR_TRUNC, 1'b1));
      end else begin
         for (int k = 0; k < n_enc; k++)
            decode_out.push_back(result_of(KIND_DATA, enc[k], NO_CODE, k == n_enc - 1));
      end
   endtask

   // Called and returns at a falling edge; valid stays up for a following transfer.
   task automatic drive_byte(input stim_row_type row);
      while (jitter_on && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_in_byte       <= row.b;
      req_start_req     <= row.st;
      req_end_of_buffer <= row.eob;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
      decode_byte(row.b, row.st, row.eob);
      case (row.chk)
         CHK_PRED: foreach (decode_out[k]) due_results.push_back(decode_out[k]);
         CHK_ONE:  due_results.push_back(result_of(row.kind, row.data, row.code, 1'b1));
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(negedge clock);
      // bytes that produce nothing may still be in the pipe
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      cap_reg = value;
   endtask

   task automatic append_uescape(ref logic [BYTE_W-1:0] text [$], input logic [15:0] value);
      logic [3:0] nib;
      text.push_back(CH_BACKSLASH);
      text.push_back(CH_U);
      for (int k = 3; k >= 0; k--) begin
         nib = value[4*k +: 4];
         if (nib < 4'd10) text.push_back(8'h30 + nib);
         else text.push_back(($urandom_range(1) ? 8'h41 : 8'h61) + nib - 8'd10);
      end
   endtask

   // Mostly well-formed strings with random content, some cut short or corrupted.
   task automatic send_string();
      logic [BYTE_W-1:0] text [$];
      logic [BYTE_W-1:0] ch;
      int                units;
      int                pick;
      int                cut;
      stim_row_type      row;
      text.push_back(CH_QUOTE);
      units = ($urandom_range(9) == 0) ? $urandom_range(6, 14) : $urandom_range(0, 5);
      repeat (units) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            do ch = BYTE_W'($urandom_range(32, 255));
            while (ch == CH_QUOTE || ch == CH_BACKSLASH);
            text.push_back(ch);
         end else if (pick < 60) begin
            text.push_back(CH_BACKSLASH);
            case ($urandom_range(5))
               0: text.push_back(CH_QUOTE);
               1: text.push_back(CH_BACKSLASH);
               2: text.push_back(CH_SLASH);
               3: text.push_back(CH_N);
               4: text.push_back(CH_R);
               default: text.push_back(CH_T);
            endcase
         end else if (pick < 70) begin
            append_uescape(text, 16'($urandom_range(0, 16'h7f)));
         end else if (pick < 78) begin
            append_uescape(text, 16'($urandom_range(16'h80, 16'h7ff)));
         end else if (pick < 86) begin
            append_uescape(text, 16'($urandom_range(16'h800, 16'hffff)));
         end else if (pick < 96) begin
            append_uescape(text, 16'($urandom_range(16'hd800, 16'hdbff)));
            append_uescape(text, 16'($urandom_range(16'hdc00, 16'hdfff)));
         end else begin
            // lone low surrogate
            append_uescape(text, 16'($urandom_range(16'hdc00, 16'hdfff)));
         end
      end
      if ($urandom_range(9) != 0) text.push_back(CH_QUOTE);
      if ($urandom_range(4) == 0)
         text[$urandom_range(text.size() - 1)] = BYTE_W'($urandom_range(255));
      pick = $urandom_range(9);
      if (pick == 0) cut = $urandom_range(text.size() - 1);
      else if (pick < 3) cut = text.size() - 1;
      else cut = -1;
      foreach (text[k]) begin
         if (sent_items >= phase_end) break;
         row     = '0;
         row.b   = text[k];
         row.st  = (k == 0);
         row.eob = (k == cut);
         row.chk = CHK_PRED;
         drive_byte(row);
      end
   endtask

   task automatic send_noise();
      stim_row_type row;
      repeat ($urandom_range(1, 6)) begin
         if (sent_items >= phase_end) break;
         row     = '0;
         row.b   = BYTE_W'($urandom_range(255));
         row.st  = ($urandom_range(5) == 0);
         row.eob = ($urandom_range(7) == 0);
         row.chk = CHK_PRED;
         drive_byte(row);
      end
   endtask

   always @(negedge clock)
      rsp_stall <= jitter_on && ($urandom_range(99) < 19);

   always @(posedge clock) begin
      decoded_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $error("unexpected result: kind %0d byte %02h code %0d last %0d",
                   rsp_kind, rsp_out_byte, rsp_error_code, rsp_last_of_run);
            mismatches++;
         end else begin
            want = due_results.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               mismatches++;
            end
            if (rsp_out_byte !== want.data) begin
               $error("out_byte: expected %02h, got %02h", want.data, rsp_out_byte);
               mismatches++;
            end
            if (rsp_error_code !== want.code) begin
               $error("error_code: expected %0d, got %0d", want.code, rsp_error_code);
               mismatches++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run: expected %0d, got %0d", want.last, rsp_last_of_run);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [CAP_W-1:0] cap_plan [8];
      cap_plan = '{13'd8191, 13'd5, 13'd0, 13'd1, 13'd3, 13'd4096, 13'd4097, 13'd0};
      cap_plan[7] = CAP_W'($urandom_range(8191));
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) drive_byte(DIRECTED_ROWS[i]);

      foreach (cap_plan[p]) begin
         quiesce();
         write_capacity(cap_plan[p]);
         // one phase runs without any gaps on either side
         jitter_on = (p != 5);
         phase_end = sent_items + ((p == 5) ? 40 : (cap_plan[p] < 2) ? 8 : 18);
         while (sent_items < phase_end) begin
            if ($urandom_range(99) < 4) quiesce();
            if ($urandom_range(99) < 20) send_noise();
            else send_string();
         end
      end

      jitter_on = 1'b1;
      quiesce();
      if (mismatches == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
